// File: design/ideabc_pkg.sv
// Shared types, constants and the modulo-65537 multiply for the IDEA block.
// No dependencies; used by ideabc_keysched and idea_block_cipher.
package ideabc_pkg;

    // Default number of rounds
    localparam int IDEA_ROUNDS = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW      = 2'd1;
    localparam logic [1:0] CFG_DECRYPT_MODE = 2'd2;

    // One subkey group: entry c holds subkey c of the group
    typedef logic [5:0][15:0] row_t;

    // Key schedule control toward the top level
    typedef struct packed {
        logic wr_en;
        logic done;
    } ks_ctl_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_GEN,
        KS_INV
    } ks_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_LOAD,
        ST_TRANS,
        ST_MIX1,
        ST_MIX2,
        ST_DONE
    } top_state_t;

    // Multiply modulo 65537, zero stands for 65536
    function automatic logic [15:0] mmul(logic [15:0] a, logic [15:0] b);
        logic [31:0] p;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] r;
        p  = 32'(a) * 32'(b);
        lo = p[15:0];
        hi = p[31:16];
        if (a == 16'd0) begin
            r = 16'd1 - b;
        end else if (b == 16'd0) begin
            r = 16'd1 - a;
        end else if (lo >= hi) begin
            r = lo - hi;
        end else begin
            r = lo - hi + 16'd1;
        end
        return r;
    endfunction

endpackage

// File: design/idea_block_cipher.sv
// IDEA block cipher top level: configuration, subkey memory and round unit.
// Depends on ideabc_pkg and ideabc_keysched.
//
// Usage: write key_high, key_low and decrypt_mode through cfg_we/cfg_index/
// cfg_wdata while the block is idle. A write to any of these three marks the
// subkey schedule stale. Words enter on s_valid/s_ready and leave on
// m_valid/m_ready. s_ready is high only while no word is in work.
// After the accept, ST_LOAD reads the first subkey group to use; each round
// then passes ST_TRANS for the multiply/add layer and ST_MIX1 and ST_MIX2 for
// the multiply-add structure, since its two dependent modulo multiplies share
// one multiplier; a last ST_TRANS applies the output transform and ST_DONE
// loads the output register. When the schedule is stale, the first word waits
// in ST_SCHED for the expansion, which in decrypt mode also inverts each
// multiplicative subkey above one (at most 2*ROUNDS+2 of them).
// Reset clears state, configuration, schedule flag and m_valid; the datapath
// and subkey memory are left as is, the memory always rebuilt before use.
// When the receiver stalls, the result waits in the output register and the
// next word is accepted and processed; it then waits until the register frees.
module idea_block_cipher #(
    parameter int ROUNDS = ideabc_pkg::IDEA_ROUNDS,
    localparam int ROWS = ROUNDS + 1,
    localparam int RW = $clog2(ROWS)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_block
);

    ideabc_pkg::top_state_t state_reg, state_next;

    logic [63:0] key_high_reg, key_high_next;
    logic [63:0] key_low_reg, key_low_next;
    logic        dec_reg, dec_next;
    logic        sready_reg, sready_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] result_reg, result_next;
    logic [15:0] v_reg [4];
    logic [15:0] v_next [4];
    logic [15:0] p_reg, p_next;
    logic [RW-1:0] grp_reg, grp_next;

    ideabc_pkg::row_t    subkey_mem [ROWS];
    ideabc_pkg::row_t    rd_reg;
    ideabc_pkg::ks_ctl_t ks_ctl;
    ideabc_pkg::row_t    ks_wr_data;
    logic [RW-1:0]       ks_wr_row;
    logic                ks_start;
    logic                rd_en;
    logic [RW-1:0]       rd_addr;

    logic        last_grp;
    logic        sel_k2;
    logic [15:0] kx, ky;
    logic [15:0] mul_a_x, mul_a_y, mul_a;
    logic [15:0] mul_b;
    logic [15:0] u;
    logic        cfg_hit;

    ideabc_keysched #(.ROUNDS(ROUNDS)) u_keysched (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ks_start),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .decrypt  (dec_reg),
        .ks_ctl   (ks_ctl),
        .wr_row   (ks_wr_row),
        .wr_data  (ks_wr_data)
    );

    assign s_ready        = (state_reg == ideabc_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_block = result_reg;
    assign ks_start       = s_ready && s_valid && !sready_reg;
    assign cfg_hit        = cfg_we && (cfg_index == ideabc_pkg::CFG_KEY_HIGH ||
                            cfg_index == ideabc_pkg::CFG_KEY_LOW ||
                            cfg_index == ideabc_pkg::CFG_DECRYPT_MODE);

    // Configuration registers and schedule flag
    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        dec_next      = dec_reg;
        sready_next   = sready_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                ideabc_pkg::CFG_KEY_HIGH:     key_high_next = cfg_wdata;
                ideabc_pkg::CFG_KEY_LOW:      key_low_next  = cfg_wdata;
                ideabc_pkg::CFG_DECRYPT_MODE: dec_next      = cfg_wdata[0];
                default: ;
            endcase
        end
        if (cfg_hit) begin
            sready_next = 1'b0;
        end else if (ks_ctl.done) begin
            sready_next = 1'b1;
        end
    end

    // Round unit operands
    assign last_grp = (grp_reg == RW'(ROUNDS));
    assign sel_k2   = !(dec_reg ^ last_grp);
    assign kx       = sel_k2 ? rd_reg[2] : rd_reg[1];
    assign ky       = sel_k2 ? rd_reg[1] : rd_reg[2];
    assign mul_b    = ideabc_pkg::mmul(v_reg[3], rd_reg[3]);
    assign mul_a    = ideabc_pkg::mmul(mul_a_x, mul_a_y);
    assign u        = p_reg + mul_a;

    always_comb begin
        unique case (state_reg)
            ideabc_pkg::ST_MIX1: begin
                mul_a_x = rd_reg[4];
                mul_a_y = v_reg[0] ^ v_reg[1];
            end
            ideabc_pkg::ST_MIX2: begin
                mul_a_x = p_reg + (v_reg[2] ^ v_reg[3]);
                mul_a_y = rd_reg[5];
            end
            default: begin
                mul_a_x = v_reg[0];
                mul_a_y = rd_reg[0];
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ideabc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sready_reg ? ideabc_pkg::ST_LOAD : ideabc_pkg::ST_SCHED;
                end
            end
            ideabc_pkg::ST_SCHED: begin
                if (ks_ctl.done) begin
                    state_next = ideabc_pkg::ST_LOAD;
                end
            end
            ideabc_pkg::ST_LOAD:  state_next = ideabc_pkg::ST_TRANS;
            ideabc_pkg::ST_TRANS: begin
                if (dec_reg ? (grp_reg == '0) : last_grp) begin
                    state_next = ideabc_pkg::ST_DONE;
                end else begin
                    state_next = ideabc_pkg::ST_MIX1;
                end
            end
            ideabc_pkg::ST_MIX1:  state_next = ideabc_pkg::ST_MIX2;
            ideabc_pkg::ST_MIX2:  state_next = ideabc_pkg::ST_TRANS;
            ideabc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ideabc_pkg::ST_IDLE;
                end
            end
            default: state_next = ideabc_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory reads and output register
    always_comb begin
        v_next       = v_reg;
        p_next       = p_reg;
        grp_next     = grp_reg;
        rd_en        = 1'b0;
        rd_addr      = grp_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ideabc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    v_next[0] = s_data_block[63:48];
                    v_next[1] = s_data_block[47:32];
                    v_next[2] = s_data_block[31:16];
                    v_next[3] = s_data_block[15:0];
                end
            end
            ideabc_pkg::ST_LOAD: begin
                rd_en    = 1'b1;
                rd_addr  = dec_reg ? RW'(ROUNDS) : '0;
                grp_next = rd_addr;
            end
            ideabc_pkg::ST_TRANS: begin
                v_next[0] = mul_a;
                v_next[3] = mul_b;
                v_next[1] = dec_reg ? v_reg[2] - kx : v_reg[2] + kx;
                v_next[2] = dec_reg ? v_reg[1] - ky : v_reg[1] + ky;
                if (dec_reg && grp_reg != '0) begin
                    rd_en    = 1'b1;
                    rd_addr  = grp_reg - RW'(1);
                    grp_next = rd_addr;
                end
            end
            ideabc_pkg::ST_MIX1: begin
                p_next = mul_a;
            end
            ideabc_pkg::ST_MIX2: begin
                v_next[0] = v_reg[0] ^ mul_a;
                v_next[1] = v_reg[1] ^ mul_a;
                v_next[2] = v_reg[2] ^ u;
                v_next[3] = v_reg[3] ^ u;
                if (!dec_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = grp_reg + RW'(1);
                    grp_next = rd_addr;
                end
            end
            ideabc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    result_next  = {v_reg[0], v_reg[1], v_reg[2], v_reg[3]};
                end
            end
            default: ;
        endcase
    end

    // Subkey memory: written by the schedule, one registered read port
    always_ff @(posedge aclk) begin
        if (ks_ctl.wr_en) begin
            subkey_mem[ks_wr_row] <= ks_wr_data;
        end
        if (rd_en) begin
            rd_reg <= subkey_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ideabc_pkg::ST_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            dec_reg      <= 1'b0;
            sready_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            dec_reg      <= dec_next;
            sready_reg   <= sready_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        p_reg      <= p_next;
        grp_reg    <= grp_next;
        result_reg <= result_next;
    end

endmodule

// File: design/ideabc_keysched.sv
// IDEA key expansion: one subkey per cycle except while a multiplicative
// subkey is inverted by repeated square-and-multiply. Uses ideabc_pkg.
module ideabc_keysched #(
    parameter int ROUNDS = ideabc_pkg::IDEA_ROUNDS,
    localparam int NSUB = 6 * ROUNDS + 4,
    localparam int ROWS = ROUNDS + 1,
    localparam int IW = $clog2(NSUB),
    localparam int RW = $clog2(ROWS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         key_high,
    input  logic [63:0]         key_low,
    input  logic                decrypt,
    output ideabc_pkg::ks_ctl_t ks_ctl,
    output logic [RW-1:0]       wr_row,
    output ideabc_pkg::row_t    wr_data
);

    ideabc_pkg::ks_state_t state_reg, state_next;
    logic [127:0]     key_reg, key_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [2:0]       col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    ideabc_pkg::row_t rowbuf_reg, rowbuf_next;
    logic [15:0]      acc_reg, acc_next;
    logic [15:0]      base_reg, base_next;
    logic [3:0]       it_reg, it_next;
    logic             ph_reg, ph_next;

    logic [2:0]  w;
    logic [15:0] word;
    logic        last;
    logic        need_inv;
    logic        inv_end;
    logic        commit;
    logic [15:0] cval;
    logic [15:0] mul_out;

    // Pick the current key word and decide on an inverse
    assign w        = idx_reg[2:0];
    assign word     = key_reg[{~w, 4'b0000} +: 16];
    assign last     = (idx_reg == IW'(NSUB - 1));
    assign need_inv = decrypt && (col_reg == 3'd0 || col_reg == 3'd3) && (word > 16'd1);
    assign inv_end  = (state_reg == ideabc_pkg::KS_INV) && ph_reg && (it_reg == 4'd15);
    assign commit   = ((state_reg == ideabc_pkg::KS_GEN) && !need_inv) || inv_end;
    assign mul_out  = ideabc_pkg::mmul(acc_reg, ph_reg ? base_reg : acc_reg);
    assign cval     = (state_reg == ideabc_pkg::KS_INV) ? mul_out : word;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ideabc_pkg::KS_IDLE: begin
                if (start) begin
                    state_next = ideabc_pkg::KS_GEN;
                end
            end
            ideabc_pkg::KS_GEN: begin
                if (need_inv) begin
                    state_next = ideabc_pkg::KS_INV;
                end else if (last) begin
                    state_next = ideabc_pkg::KS_IDLE;
                end
            end
            ideabc_pkg::KS_INV: begin
                if (inv_end) begin
                    state_next = last ? ideabc_pkg::KS_IDLE : ideabc_pkg::KS_GEN;
                end
            end
            default: state_next = ideabc_pkg::KS_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        key_next    = key_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rowbuf_next = rowbuf_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        it_next     = it_reg;
        ph_next     = ph_reg;
        wr_data     = rowbuf_reg;
        wr_data[col_reg] = cval;
        wr_row      = row_reg;
        ks_ctl.wr_en = commit && (col_reg == 3'd5 || last);
        ks_ctl.done  = commit && last;

        if (state_reg == ideabc_pkg::KS_IDLE && start) begin
            key_next = {key_high, key_low};
            idx_next = '0;
            col_next = '0;
            row_next = '0;
        end
        if (state_reg == ideabc_pkg::KS_GEN && need_inv) begin
            base_next = word;
            acc_next  = 16'd1;
            it_next   = '0;
            ph_next   = 1'b0;
        end
        // Square, then multiply by the base: after 16 passes acc = base^65535
        if (state_reg == ideabc_pkg::KS_INV) begin
            acc_next = mul_out;
            ph_next  = !ph_reg;
            if (ph_reg) begin
                it_next = it_reg + 4'd1;
            end
        end
        // Store the subkey and advance
        if (commit) begin
            rowbuf_next[col_reg] = cval;
            idx_next = idx_reg + IW'(1);
            if (col_reg == 3'd5) begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end else begin
                col_next = col_reg + 3'd1;
            end
            if (w == 3'd7) begin
                key_next = {key_reg[102:0], key_reg[127:103]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ideabc_pkg::KS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        rowbuf_reg <= rowbuf_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        it_reg     <= it_next;
        ph_reg     <= ph_next;
    end

endmodule
